// ===== rtl/apra_pkg.sv =====
// Package with shared constants and types of the aligned page run allocator.
package apra_pkg;
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W = 20;
	localparam int ENTRY_W = 2 * PAGE_W;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ADD,
		CMD_SCAN_START,
		CMD_SCAN_READ,
		CMD_SCAN_EVAL,
		CMD_SPLIT,
		CMD_CARVE,
		CMD_SHIFT_READ,
		CMD_SHIFT_WRITE,
		CMD_SHIFT_DONE,
		CMD_CLEAR_LAST
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
		logic len_zero;
		logic table_full;
		logic scan_end;
		logic hit;
		logic top_zero;
		logic carve_empty;
		logic shift_end;
	} status_t;
endpackage

// ===== rtl/apra_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface apra_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [19:0] free_base_page;
	logic [19:0] free_page_count;
	logic [31:0] request_bytes;
	logic [31:0] align_bytes;
	modport source (output valid, mode, free_base_page, free_page_count,
		request_bytes, align_bytes, input ready);
	modport sink (input valid, mode, free_base_page, free_page_count,
		request_bytes, align_bytes, output ready);
endinterface

interface apra_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] phys_address;
	logic        failed;
	logic        table_overflow;
	modport source (output valid, phys_address, failed, table_overflow, input ready);
	modport sink (input valid, phys_address, failed, table_overflow, output ready);
endinterface

// ===== rtl/apra_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module apra_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/apra_datapath.sv =====
// Datapath: run table memory, scan index, request registers and arithmetic.
module apra_datapath #(
	parameter int TABLE_ENTRIES = apra_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  apra_pkg::cmd_t       cmd,
	input  logic                 pass2,
	apra_in_if.sink              in_ch,
	output apra_pkg::status_t    status,
	output logic [31:0]          phys_address
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int PW = apra_pkg::PAGE_W;

	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          mode_q;
	logic [PW-1:0] base_in_q, len_in_q, req_q, am_q;
	logic [PW-1:0] rbase, rlen, ebase_q, elen_q;
	logic [CW-1:0] pick_q;
	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [2*PW-1:0] wdata, rdata;

	apra_ram #(.WIDTH(2 * PW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rbase = rdata[2*PW-1:PW];
	assign rlen  = rdata[PW-1:0];

	// Per-entry tests on the word just read.
	logic [PW-1:0] low_bits, mis;
	logic [PW:0]   need;
	logic          fit_aligned, fit_split;
	assign low_bits    = rbase & am_q;
	assign mis         = am_q - low_bits + 1'b1;
	assign need        = {1'b0, req_q} + {1'b0, mis};
	assign fit_aligned = (low_bits == '0) && (rlen >= req_q);
	assign fit_split   = ({1'b0, rlen} >= need);

	// Split arithmetic on the held entry.
	logic [PW-1:0] emis, top_len, top_base;
	assign emis     = am_q - (ebase_q & am_q) + 1'b1;
	assign top_len  = elen_q - emis;
	assign top_base = ebase_q + emis;

	always_comb begin
		status.mode        = mode_q;
		status.len_zero    = (len_in_q == '0);
		status.table_full  = (used_q == CW'(TABLE_ENTRIES));
		status.scan_end    = (idx_q >= used_q);
		status.hit         = pass2 ? fit_split : fit_aligned;
		status.top_zero    = (top_len == '0);
		status.carve_empty = (elen_q == req_q);
		status.shift_end   = (idx_q + 1'b1 >= used_q);
	end

	// Memory port selection per command.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = '0;
		raddr = idx_q[IW-1:0];
		case (cmd)
			apra_pkg::CMD_ADD: begin
				we = 1'b1; waddr = used_q[IW-1:0]; wdata = {base_in_q, len_in_q};
			end
			apra_pkg::CMD_SPLIT: begin
				we = 1'b1; waddr = pick_q[IW-1:0]; wdata = {ebase_q, emis};
			end
			apra_pkg::CMD_CARVE: begin
				we = 1'b1; waddr = pick_q[IW-1:0];
				wdata = {ebase_q + req_q, elen_q - req_q};
			end
			apra_pkg::CMD_SHIFT_READ: raddr = IW'(idx_q + 1'b1);
			apra_pkg::CMD_SHIFT_WRITE: begin
				we = 1'b1; waddr = idx_q[IW-1:0]; wdata = rdata;
			end
			apra_pkg::CMD_CLEAR_LAST: begin
				we = 1'b1; waddr = IW'(used_q - 1'b1); wdata = '0;
			end
			default: ;
		endcase
	end

	// Control registers: fill count and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
		end else begin
			case (cmd)
				apra_pkg::CMD_ADD:         used_q <= used_q + 1'b1;
				apra_pkg::CMD_SCAN_START:  idx_q <= '0;
				apra_pkg::CMD_SCAN_EVAL:   idx_q <= idx_q + 1'b1;
				apra_pkg::CMD_SPLIT:       used_q <= used_q + 1'b1;
				apra_pkg::CMD_CARVE:       idx_q <= pick_q;
				apra_pkg::CMD_SHIFT_WRITE: idx_q <= idx_q + 1'b1;
				apra_pkg::CMD_CLEAR_LAST:  used_q <= used_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd)
			apra_pkg::CMD_LOAD: begin
				mode_q    <= in_ch.mode;
				base_in_q <= in_ch.free_base_page;
				len_in_q  <= in_ch.free_page_count;
				req_q     <= in_ch.request_bytes[31:12];
				am_q      <= (in_ch.align_bytes[31:12] == '0) ? '0 :
					in_ch.align_bytes[31:12] - 1'b1;
				phys_address <= '0;
			end
			apra_pkg::CMD_SCAN_EVAL: begin
				ebase_q <= rbase;
				elen_q  <= rlen;
				pick_q  <= idx_q;
			end
			apra_pkg::CMD_SPLIT: begin
				ebase_q <= top_base;
				elen_q  <= top_len;
				pick_q  <= used_q;
			end
			apra_pkg::CMD_CARVE: phys_address <= {ebase_q, 12'h000};
			default: ;
		endcase
	end
endmodule

// ===== rtl/apra_ctrl.sv =====
// Controller state machine sequencing adds, scans, splits and compaction.
module apra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  apra_pkg::status_t status,
	input  logic              in_valid,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output logic              failed,
	output logic              table_overflow,
	output apra_pkg::cmd_t    cmd,
	output logic              pass2
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SREAD, S_SEVAL, S_SPLIT, S_CARVE,
		S_SHRD, S_SHWR, S_CLEAR, S_DONE
	} state_t;

	state_t state_q;
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = apra_pkg::CMD_NONE;
		case (state_q)
			S_IDLE:   if (in_valid && in_ready) cmd = apra_pkg::CMD_LOAD;
			S_DECODE: cmd = status.mode ? apra_pkg::CMD_SCAN_START :
				((!status.len_zero && !status.table_full) ? apra_pkg::CMD_ADD :
				apra_pkg::CMD_NONE);
			S_SREAD:  cmd = apra_pkg::CMD_SCAN_READ;
			S_SEVAL:  if (status.scan_end)
				cmd = pass2 ? apra_pkg::CMD_NONE : apra_pkg::CMD_SCAN_START;
			else cmd = apra_pkg::CMD_SCAN_EVAL;
			S_SPLIT:  if (!status.table_full && !status.top_zero) cmd = apra_pkg::CMD_SPLIT;
			S_CARVE:  cmd = apra_pkg::CMD_CARVE;
			S_SHRD:   cmd = apra_pkg::CMD_SHIFT_READ;
			S_SHWR:   cmd = apra_pkg::CMD_SHIFT_WRITE;
			S_CLEAR:  cmd = apra_pkg::CMD_CLEAR_LAST;
			default:  cmd = apra_pkg::CMD_NONE;
		endcase
	end

	// A hit in either pass is captured, with its index, by the eval command.
	logic hold_hit;
	assign hold_hit = (state_q == S_SEVAL) && !status.scan_end && status.hit;

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; failed <= 1'b0;
			table_overflow <= 1'b0; pass2 <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_DECODE; failed <= 1'b0;
					table_overflow <= 1'b0; pass2 <= 1'b0;
				end
				S_DECODE: if (status.mode) state_q <= S_SREAD;
				else begin
					table_overflow <= !status.len_zero && status.table_full;
					state_q <= S_DONE;
				end
				S_SREAD: state_q <= S_SEVAL;
				S_SEVAL: begin
					if (status.scan_end) begin
						if (pass2) begin failed <= 1'b1; state_q <= S_DONE; end
						else begin pass2 <= 1'b1; state_q <= S_SREAD; end
					end else if (hold_hit) state_q <= pass2 ? S_SPLIT : S_CARVE;
					else state_q <= S_SREAD;
				end
				S_SPLIT: begin
					if (status.table_full) begin
						failed <= 1'b1; table_overflow <= 1'b1; state_q <= S_DONE;
					end else if (status.top_zero) begin
						failed <= 1'b1; state_q <= S_DONE;
					end else state_q <= S_CARVE;
				end
				S_CARVE: state_q <= status.carve_empty ? S_SHRD : S_DONE;
				S_SHRD: state_q <= status.shift_end ? S_CLEAR : S_SHWR;
				S_SHWR: state_q <= S_SHRD;
				S_CLEAR: state_q <= S_DONE;
				S_DONE: begin out_valid <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result never appears while an item is still being worked on.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_IDLE)) else $error("result outside idle");
	// Overflow on an allocation always comes with failure.
	a_ovf_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status.mode && table_overflow) |-> failed)
		else $error("overflow without failure");
	// Results only follow the done state.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE)) else $error("stray result");
endmodule

// ===== rtl/aligned_page_run_allocator_core.sv =====
// Top level of the aligned page run allocator: controller plus datapath.
//  channel | dir | payload
//  in_ch   | in  | mode, free_base_page, free_page_count, request_bytes, align_bytes
//  out_ch  | out | phys_address, failed, table_overflow
// An allocation makes up to two scans of the table, each entry read and then
// judged through the registered RAM read port, plus a compaction that moves the
// later words down one place, each word read and then written back.
// One item is worked at a time; a new item is taken once the result is delivered.
// Reset empties the table at once through the fill count; no clearing pass.
module aligned_page_run_allocator_core #(
	parameter int TABLE_ENTRIES = apra_pkg::TABLE_ENTRIES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	apra_in_if.sink  in_ch,
	apra_out_if.source out_ch
);
	apra_pkg::cmd_t    cmd;
	apra_pkg::status_t status;
	logic              pass2;

	apra_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .pass2(pass2), .in_ch(in_ch),
		.status(status), .phys_address(out_ch.phys_address)
	);

	apra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .status(status), .in_valid(in_ch.valid),
		.out_ready(out_ch.ready), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
		.failed(out_ch.failed), .table_overflow(out_ch.table_overflow),
		.cmd(cmd), .pass2(pass2)
	);
endmodule
